FILE: sv/isotp_pkg.sv
package isotp_pkg;

  localparam int unsigned JOB_DEPTH = 2;

  localparam int unsigned FIRST_DATA = 6;
  localparam int unsigned CONSEC_DATA = 7;

  localparam logic [3:0] PCI_FIRST = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;
  localparam logic [3:0] SEQ_START = 4'h1;
  localparam logic [3:0] SEQ_MAX = 4'hF;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_BAD_TYPE = 2'd1;
  localparam logic [1:0] STAT_BAD_SEQ = 2'd2;

  typedef enum logic {
    RX_IDLE,
    RX_MSG
  } rx_state_e;

  typedef struct packed {
    logic [7:0] pci_byte;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
  } in_frame_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] byte_offset;
    logic [1:0]  status;
    logic        message_done;
    logic        last;
  } out_item_t;

  // one request worth of work for the output side
  typedef struct packed {
    logic [6:0][7:0] data;
    logic [2:0]      count;
    logic [11:0]     base;
    logic [1:0]      status;
    logic            done;
  } job_t;

endpackage

FILE: sv/isotp_front.sv
module isotp_front
  import isotp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_frame_t frame_i,
  output logic      job_valid_o,
  output job_t      job_o
);

  rx_state_e   state_q, state_d;
  logic [11:0] total_q, total_d;
  logic [11:0] bw_q, bw_d;
  logic [3:0]  seq_q, seq_d;

  logic [3:0]  pci_type;
  logic [3:0]  pci_low;
  logic [11:0] first_len;
  logic [11:0] remaining;
  logic [2:0]  first_chunk;
  logic [2:0]  consec_chunk;
  logic        first_ok;
  logic        consec_ok;

  assign pci_type = frame_i.pci_byte[7:4];
  assign pci_low = frame_i.pci_byte[3:0];
  assign first_len = {pci_low, frame_i.frame_byte1};
  assign remaining = total_q - bw_q;
  assign first_chunk = (first_len < 12'(FIRST_DATA)) ? first_len[2:0] : 3'(FIRST_DATA);
  assign consec_chunk = (remaining < 12'(CONSEC_DATA)) ? remaining[2:0] : 3'(CONSEC_DATA);
  assign first_ok = (pci_type == PCI_FIRST);
  assign consec_ok = (pci_type == PCI_CONSEC) && (pci_low == seq_q);

  // next state
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      case (state_q)
        RX_IDLE: begin
          if (first_ok && (12'(first_chunk) < first_len)) begin
            state_d = RX_MSG;
          end
        end
        RX_MSG: begin
          if (!consec_ok || (remaining <= 12'(CONSEC_DATA))) begin
            state_d = RX_IDLE;
          end
        end
        default: state_d = RX_IDLE;
      endcase
    end
  end

  // outputs and message bookkeeping
  always_comb begin
    total_d = total_q;
    bw_d = bw_q;
    seq_d = seq_q;
    job_valid_o = 1'b0;
    job_o.data = '0;
    job_o.count = 3'd1;
    job_o.base = bw_q;
    job_o.status = STAT_OK;
    job_o.done = 1'b0;
    case (state_q)
      RX_IDLE: begin
        job_o.base = '0;
        if (!first_ok) begin
          job_valid_o = accept_i;
          job_o.status = STAT_BAD_TYPE;
          if (accept_i) begin
            bw_d = '0;
          end
        end else begin
          job_valid_o = accept_i && (first_chunk != 3'd0);
          job_o.data = {8'h00, frame_i.frame_byte7, frame_i.frame_byte6,
                        frame_i.frame_byte5, frame_i.frame_byte4,
                        frame_i.frame_byte3, frame_i.frame_byte2};
          job_o.count = first_chunk;
          job_o.done = (12'(first_chunk) == first_len);
          if (accept_i) begin
            total_d = first_len;
            bw_d = 12'(first_chunk);
            seq_d = SEQ_START;
          end
        end
      end
      RX_MSG: begin
        job_valid_o = accept_i;
        if (pci_type != PCI_CONSEC) begin
          job_o.status = STAT_BAD_TYPE;
        end else if (pci_low != seq_q) begin
          job_o.status = STAT_BAD_SEQ;
        end else begin
          job_o.data = {frame_i.frame_byte7, frame_i.frame_byte6,
                        frame_i.frame_byte5, frame_i.frame_byte4,
                        frame_i.frame_byte3, frame_i.frame_byte2,
                        frame_i.frame_byte1};
          job_o.count = consec_chunk;
          job_o.done = (remaining <= 12'(CONSEC_DATA));
          if (accept_i) begin
            bw_d = bw_q + 12'(consec_chunk);
            seq_d = (seq_q == SEQ_MAX) ? SEQ_START : seq_q + 4'd1;
          end
        end
      end
      default: job_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RX_IDLE;
      total_q <= '0;
      bw_q <= '0;
      seq_q <= SEQ_START;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      bw_q <= bw_d;
      seq_q <= seq_d;
    end
  end

  a_seq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q != 4'd0)
    else $error("sequence counter reached zero");

  a_msg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == RX_MSG |-> bw_q < total_q)
    else $error("open message with nothing left");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.status != STAT_OK |-> job_o.count == 3'd1 && !job_o.done)
    else $error("error job not a single result");

endmodule

FILE: sv/isotp_jobq.sv
module isotp_jobq
  import isotp_pkg::*;
#(
  parameter int unsigned Depth = JOB_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign job_o = slots_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue overfilled");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> wr_q == rd_q)
    else $error("job queue pointers out of step");

endmodule

FILE: sv/isotp_back.sv
module isotp_back
  import isotp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      empty_i,
  input  logic      pop_i,
  output logic      deq_o,
  output out_item_t result_o
);

  logic [2:0] idx_q, idx_d;
  logic       take;
  logic       at_last;

  assign take = pop_i && !empty_i;
  assign at_last = (idx_q == job_i.count - 3'd1);
  assign deq_o = take && at_last;

  assign result_o.data_byte = (job_i.status == STAT_OK) ? job_i.data[idx_q] : 8'h00;
  assign result_o.byte_offset = job_i.base + 12'(idx_q);
  assign result_o.status = job_i.status;
  assign result_o.message_done = job_i.done && at_last;
  assign result_o.last = at_last;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < job_i.count)
    else $error("byte index past job length");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 3'd0)
    else $error("byte index not cleared between jobs");

endmodule

FILE: sv/isotp_reassembler.sv
// channel   | handshake         | payload
// ----------+-------------------+--------------------------
// frames in | push / full       | frame_i  (in_frame_t)
// bytes out | empty / pop       | result_o (out_item_t)
//
// a frame is classified in the cycle it is taken; state updates at once
// each frame yields 0 to 7 results, one per cycle while pop is high, walked out of the job queue
// a new frame is taken every cycle while the job queue has room
// rst_ni clears the message state and empties the queue; no clearing pass
// a stalled pop holds the current result and backs up into full
module isotp_reassembler
  import isotp_pkg::*;
#(
  parameter int unsigned JobDepth = JOB_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_frame_t frame_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  logic accept;
  logic job_valid;
  job_t front_job;
  job_t head_job;
  logic deq;

  assign accept = push && !full;

  isotp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .frame_i    (frame_i),
    .job_valid_o(job_valid),
    .job_o      (front_job)
  );

  isotp_jobq #(
    .Depth(JobDepth)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (deq),
    .job_o  (head_job),
    .empty_o(empty)
  );

  isotp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_i   (pop),
    .deq_o   (deq),
    .result_o(result_o)
  );

endmodule
